// ===== design/mfq_pkg.sv =====
`timescale 1ns / 1ps

package mfq_pkg;

    // default sizes
    localparam int DEF_NUM_LEVELS  = 5;
    localparam int DEF_QUEUE_DEPTH = 64;

    // field widths
    localparam int ACT_W   = 2;
    localparam int LVL_W   = 3;
    localparam int ID_W    = 6;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 7;

    typedef logic [ACT_W-1:0]   t_action;
    typedef logic [LVL_W-1:0]   t_level;
    typedef logic [ID_W-1:0]    t_pid;
    typedef logic [ST_W-1:0]    t_status;
    typedef logic [COUNT_W-1:0] t_count;

    // action codes
    localparam t_action ACT_PUSH   = 2'd0;
    localparam t_action ACT_POP    = 2'd1;
    localparam t_action ACT_REMOVE = 2'd2;

    // status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

endpackage

// ===== design/mfq_if.sv =====
`timescale 1ns / 1ps

// request channel: one action word
interface mfq_in_if;
    import mfq_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_level  queue_level;
    t_pid    process_id;

    modport source (output valid, output action, output queue_level, output process_id,
                    input ready);
    modport sink   (input valid, input action, input queue_level, input process_id,
                    output ready);
endinterface

// response channel: one result word
interface mfq_out_if;
    import mfq_pkg::*;

    logic    valid;
    logic    ready;
    t_pid    popped_id;
    t_status status;
    t_count  level_count;

    modport source (output valid, output popped_id, output status, output level_count,
                    input ready);
    modport sink   (input valid, input popped_id, input status, input level_count,
                    output ready);
endinterface

// ===== design/multilevel_fifo_with_removal.sv =====
`timescale 1ns / 1ps
// Push, unknown action or bad level: the accepted word goes straight to S_OUT and
// from there into the output register. Pop walks the level row in S_SHIFT; remove
// walks it in S_SCAN and, when found, again in S_SHIFT, both by the single read port.
// Throughput: one word at a time; the next word is taken once the current one
// has moved into the output register. Reset clears the level counts at once;
// the identifier store needs no clearing.
module multilevel_fifo_with_removal #(
    parameter int NUM_LEVELS  = mfq_pkg::DEF_NUM_LEVELS,
    parameter int QUEUE_DEPTH = mfq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfq_in_if.sink    i_req,
    mfq_out_if.source o_rsp
);
    import mfq_pkg::*;

    localparam int LIX_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_counts [NUM_LEVELS];
    logic [ID_W-1:0]   r_store [MEM_DEPTH];
    logic [ID_W-1:0]   r_rdata;

    t_action           r_act;
    t_pid              r_id;
    logic [LIX_W-1:0]  r_lvl;
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_pos;
    logic              r_found;
    t_pid              r_popped;
    t_status           r_status;

    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_dq_idx;
    logic              r_dq_vld;

    logic              r_ovalid;
    t_pid              r_o_popped;
    t_status           r_o_status;
    t_count            r_o_count;

    logic              w_in_acc;
    logic              w_lvl_ok;
    logic [LIX_W-1:0]  w_lvl_idx;
    logic [CNT_W-1:0]  w_cnt_cur;
    logic [ADDR_W-1:0] w_base_in;
    logic              w_push_ok;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ID_W-1:0]   w_wr_data;
    logic              w_walk_done;

    // input decode
    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_lvl_ok    = int'(i_req.queue_level) < NUM_LEVELS;
    assign w_lvl_idx   = LIX_W'(i_req.queue_level);
    assign w_cnt_cur   = w_lvl_ok ? r_counts[w_lvl_idx] : '0;
    assign w_base_in   = ADDR_W'(w_lvl_idx * QUEUE_DEPTH);
    assign w_push_ok   = w_lvl_ok && (w_cnt_cur != CNT_W'(QUEUE_DEPTH));

    // row walk read port, shared by scan and shift
    assign w_rd_en     = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_rd_idx < r_cnt);
    assign w_rd_addr   = r_base + ADDR_W'(r_rd_idx);
    assign w_walk_done = !w_rd_en && !r_dq_vld;

    // write port: tail append on push, move one slot forward on shift
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_base + ADDR_W'(r_dq_idx - CNT_W'(1));
        w_wr_data = r_rdata;
        if (r_state == S_IDLE) begin
            w_wr_en   = w_in_acc && (i_req.action == ACT_PUSH) && w_push_ok;
            w_wr_addr = w_base_in + ADDR_W'(w_cnt_cur);
            w_wr_data = i_req.process_id;
        end else if (r_state == S_SHIFT) begin
            w_wr_en   = r_dq_vld && (r_dq_idx != r_pos);
        end
    end

    // identifier store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_store[w_rd_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dq_vld <= 1'b0;
            r_counts <= '{default: '0};
        end else begin
            r_dq_vld <= w_rd_en;
            r_dq_idx <= r_rd_idx;
            if (w_rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_act    <= i_req.action;
                        r_id     <= i_req.process_id;
                        r_lvl    <= w_lvl_idx;
                        r_base   <= w_base_in;
                        r_cnt    <= w_cnt_cur;
                        r_pos    <= '0;
                        r_found  <= 1'b0;
                        r_popped <= '0;
                        r_rd_idx <= '0;
                        r_status <= ST_OK;
                        r_state  <= S_OUT;
                        case (i_req.action)
                            ACT_PUSH: begin
                                if (!w_push_ok) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_cnt               <= w_cnt_cur + CNT_W'(1);
                                    r_counts[w_lvl_idx] <= w_cnt_cur + CNT_W'(1);
                                end
                            end
                            ACT_POP: begin
                                if (w_cnt_cur == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SHIFT;
                                end
                            end
                            ACT_REMOVE: begin
                                if (w_cnt_cur == '0) begin
                                    r_status <= ST_NOT_FOUND;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // find the last matching entry of the row
                S_SCAN: begin
                    if (r_dq_vld && (r_rdata == r_id)) begin
                        r_found <= 1'b1;
                        r_pos   <= r_dq_idx;
                    end
                    if (w_walk_done) begin
                        if (r_found) begin
                            r_rd_idx <= r_pos;
                            r_state  <= S_SHIFT;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_OUT;
                        end
                    end
                end

                // close the gap at r_pos; the head word is caught on pop
                S_SHIFT: begin
                    if (r_dq_vld && (r_dq_idx == r_pos) && (r_act == ACT_POP)) begin
                        r_popped <= r_rdata;
                    end
                    if (w_walk_done) begin
                        r_cnt           <= r_cnt - CNT_W'(1);
                        r_counts[r_lvl] <= r_cnt - CNT_W'(1);
                        r_state         <= S_OUT;
                    end
                end

                // hand the result to the output register
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_popped <= r_popped;
                        r_o_status <= r_status;
                        r_o_count  <= COUNT_W'(r_cnt);
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.popped_id   = r_o_popped;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.level_count = r_o_count;

endmodule

// ===== design/mfq_checker.sv =====
`timescale 1ns / 1ps

module mfq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input mfq_pkg::t_pid    i_popped_id,
    input mfq_pkg::t_status i_status,
    input mfq_pkg::t_count  i_level_count
);
    import mfq_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_popped_id)
            && $stable(i_status) && $stable(i_level_count))
        else $error("result word changed while stalled");

    // one word in flight: the request side closes after an accept
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // a failed action returns no identifier
    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> i_popped_id == '0)
        else $error("identifier on failed action");

    // an empty report carries a zero count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY) |-> i_level_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind multilevel_fifo_with_removal mfq_checker u_mfq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_popped_id   (o_rsp.popped_id),
    .i_status      (o_rsp.status),
    .i_level_count (o_rsp.level_count)
);

// ===== dv/multilevel_fifo_with_removal_test.sv =====
`timescale 1ns / 1ps

module multilevel_fifo_with_removal_test;
    import mfq_pkg::*;

    localparam int NUM_LEVELS  = DEF_NUM_LEVELS;
    localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
    // cycles with no word moving on either side before giving up
    localparam int STALL_LIMIT = 4000;
    // longest remove walks the row about twice
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

    // action code the block leaves undefined
    localparam t_action ACT_NONE = 2'd3;

    typedef struct packed {
        t_pid    pid;
        t_status st;
        t_count  cnt;
    } t_result;

    typedef struct packed {
        t_action act;
        t_level  lvl;
        t_pid    pid;
        logic    fixed;
        t_pid    e_pid;
        t_status e_st;
        t_count  e_cnt;
    } t_stim_row;

    localparam int N_DIR = 20;

    // directed words; fixed rows carry the result that must come back
    localparam t_stim_row DIR_ROWS [N_DIR] = '{
        '{ACT_POP,    3'd0, 6'd0,  1'b1, 6'd0, ST_EMPTY,     7'd0},
        '{ACT_REMOVE, 3'd1, 6'd9,  1'b1, 6'd0, ST_NOT_FOUND, 7'd0},
        '{ACT_PUSH,   3'd0, 6'd63, 1'b1, 6'd0, ST_OK,        7'd1},
        '{ACT_PUSH,   3'd0, 6'd0,  1'b1, 6'd0, ST_OK,        7'd2},
        '{ACT_PUSH,   3'd0, 6'd63, 1'b1, 6'd0, ST_OK,        7'd3},
        '{ACT_PUSH,   3'd0, 6'd21, 1'b1, 6'd0, ST_OK,        7'd4},
        '{ACT_REMOVE, 3'd0, 6'd63, 1'b0, 6'd0, ST_OK,        7'd0},
        '{ACT_POP,    3'd0, 6'd0,  1'b0, 6'd0, ST_OK,        7'd0},
        '{ACT_PUSH,   3'd4, 6'd42, 1'b1, 6'd0, ST_OK,        7'd1},
        '{ACT_PUSH,   3'd5, 6'd7,  1'b1, 6'd0, ST_FULL,      7'd0},
        '{ACT_PUSH,   3'd7, 6'd63, 1'b1, 6'd0, ST_FULL,      7'd0},
        '{ACT_POP,    3'd6, 6'd0,  1'b1, 6'd0, ST_EMPTY,     7'd0},
        '{ACT_REMOVE, 3'd7, 6'd63, 1'b1, 6'd0, ST_NOT_FOUND, 7'd0},
        '{ACT_NONE,   3'd0, 6'd63, 1'b0, 6'd0, ST_OK,        7'd0},
        '{ACT_NONE,   3'd7, 6'd63, 1'b1, 6'd0, ST_OK,        7'd0},
        '{ACT_REMOVE, 3'd4, 6'd42, 1'b0, 6'd0, ST_OK,        7'd0},
        '{ACT_REMOVE, 3'd0, 6'd5,  1'b0, 6'd0, ST_OK,        7'd0},
        '{ACT_POP,    3'd0, 6'd0,  1'b0, 6'd0, ST_OK,        7'd0},
        '{ACT_POP,    3'd0, 6'd0,  1'b0, 6'd0, ST_OK,        7'd0},
        '{ACT_POP,    3'd0, 6'd0,  1'b1, 6'd0, ST_EMPTY,     7'd0}
    };

    logic i_clk;
    logic i_rst_n;

    mfq_in_if  req_if ();
    mfq_out_if rsp_if ();

    multilevel_fifo_with_removal #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow of the level rows and their counts
    t_pid    pid_rows [NUM_LEVELS][QUEUE_DEPTH];
    int      lvl_cnt [NUM_LEVELS] = '{default: 0};
    t_result pending_results [$];
    int      errors      = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      words_sent  = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // shift the later entries of a level forward over pos
    function automatic void close_row(int lvl, int pos, int n);
        for (int i = pos + 1; i < n; i++) pid_rows[lvl][i-1] = pid_rows[lvl][i];
    endfunction

    // apply one word to the shadow and return the result it must give
    function automatic t_result queue_update(t_action a, t_level l, t_pid p);
        t_result r;
        int      n;
        int      hit;
        r   = '{pid: '0, st: ST_OK, cnt: '0};
        hit = -1;
        if (int'(l) >= NUM_LEVELS) begin
            case (a)
                ACT_PUSH:   r.st = ST_FULL;
                ACT_POP:    r.st = ST_EMPTY;
                ACT_REMOVE: r.st = ST_NOT_FOUND;
                default:    r.st = ST_OK;
            endcase
        end else begin
            n = lvl_cnt[l];
            case (a)
                ACT_PUSH: begin
                    if (n >= QUEUE_DEPTH) begin
                        r.st = ST_FULL;
                    end else begin
                        pid_rows[l][n] = p;
                        n++;
                    end
                end
                ACT_POP: begin
                    if (n == 0) begin
                        r.st = ST_EMPTY;
                    end else begin
                        r.pid = pid_rows[l][0];
                        close_row(l, 0, n);
                        n--;
                    end
                end
                ACT_REMOVE: begin
                    // the last match goes
                    for (int i = 0; i < n; i++) if (pid_rows[l][i] == p) hit = i;
                    if (hit < 0) begin
                        r.st = ST_NOT_FOUND;
                    end else begin
                        close_row(l, hit, n);
                        n--;
                    end
                end
                default: ;
            endcase
            lvl_cnt[l] = n;
            r.cnt      = t_count'(n);
        end
        return r;
    endfunction

    // half the ids from a narrow range so duplicates show up
    function automatic t_pid rand_pid();
        if ($urandom_range(0, 1) == 1) return t_pid'($urandom_range(0, 3));
        return t_pid'($urandom_range(0, 63));
    endfunction

    // offer one word, called and returning at a rising edge
    task automatic send_word(input t_action a, input t_level l, input t_pid p,
                             input logic fixed, input t_result want);
        t_result r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= a;
        req_if.queue_level <= l;
        req_if.process_id  <= p;
        do @(posedge i_clk); while (!req_if.ready);
        r = queue_update(a, l, p);
        pending_results.push_back(fixed ? want : r);
        words_sent++;
    endtask

    // fill one level past full
    task automatic fill_level(input t_level l);
        while (lvl_cnt[l] < QUEUE_DEPTH) send_word(ACT_PUSH, l, rand_pid(), 1'b0, '0);
        repeat ($urandom_range(1, 2)) send_word(ACT_PUSH, l, rand_pid(), 1'b0, '0);
    endtask

    // random bursts of well-formed traffic with some noise mixed in
    task automatic run_random(input int target, input int tx_pct, input int rx_pct);
        int     first;
        int     kind;
        t_level l;
        t_pid   p;
        first       = words_sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        fill_level(t_level'($urandom_range(0, NUM_LEVELS - 1)));
        while (words_sent - first < target) begin
            kind = $urandom_range(0, 99);
            l    = t_level'($urandom_range(0, NUM_LEVELS - 1));
            if (kind < 6) begin
                fill_level(l);
            end else if (kind < 12) begin
                // drain to empty and one more
                while (lvl_cnt[l] > 0) send_word(ACT_POP, l, rand_pid(), 1'b0, '0);
                send_word(ACT_POP, l, rand_pid(), 1'b0, '0);
            end else if (kind < 42) begin
                repeat ($urandom_range(1, 12)) send_word(ACT_PUSH, l, rand_pid(), 1'b0, '0);
            end else if (kind < 62) begin
                repeat ($urandom_range(1, 8)) send_word(ACT_POP, l, rand_pid(), 1'b0, '0);
            end else if (kind < 87) begin
                // mostly ids that are present, anywhere in the row
                repeat ($urandom_range(1, 6)) begin
                    if (lvl_cnt[l] > 0 && $urandom_range(0, 9) < 7)
                        p = pid_rows[l][$urandom_range(0, lvl_cnt[l] - 1)];
                    else
                        p = rand_pid();
                    send_word(ACT_REMOVE, l, p, 1'b0, '0);
                end
            end else begin
                send_word(t_action'($urandom_range(0, 3)), t_level'($urandom_range(0, 7)),
                          t_pid'($urandom_range(0, 63)), 1'b0, '0);
            end
        end
    endtask

    // response side back-pressure
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // compare each result word with the oldest pending one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: popped_id %0d status %0d count %0d",
                       rsp_if.popped_id, rsp_if.status, rsp_if.level_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.popped_id !== want.pid) begin
                    $error("popped_id: expected %0d, got %0d", want.pid, rsp_if.popped_id);
                    errors++;
                end
                if (rsp_if.status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, rsp_if.status);
                    errors++;
                end
                if (rsp_if.level_count !== want.cnt) begin
                    $error("level_count: expected %0d, got %0d", want.cnt, rsp_if.level_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on words moving through either side
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("FAIL multilevel_fifo_with_removal");
        $finish;
    end

    // stimulus
    initial begin
        req_if.valid       = 1'b0;
        req_if.action      = ACT_PUSH;
        req_if.queue_level = '0;
        req_if.process_id  = '0;
        i_rst_n            = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under light sender and heavy receiver idling
        tx_idle_pct = 8;
        rx_idle_pct = 85;
        for (int i = 0; i < N_DIR; i++)
            send_word(DIR_ROWS[i].act, DIR_ROWS[i].lvl, DIR_ROWS[i].pid, DIR_ROWS[i].fixed,
                      '{pid: DIR_ROWS[i].e_pid, st: DIR_ROWS[i].e_st, cnt: DIR_ROWS[i].e_cnt});

        run_random(320, 8, 85);
        run_random(320, 85, 8);
        run_random(340, 0, 0);
        req_if.valid <= 1'b0;

        // let the last results come back, then allow for stragglers
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("PASS multilevel_fifo_with_removal");
        else
            $display("FAIL multilevel_fifo_with_removal");
        $finish;
    end

endmodule
